@@ hw/rtl/brrip_pkg.sv @@
`timescale 1ns / 1ps

package brrip_pkg;

  // Default geometry
  localparam int RRPV_BITS_DEF = 2;
  localparam int WAYS_DEF      = 16;
  localparam int SETS_DEF      = 256;

  // Fixed field widths of the stream payload
  localparam int SET_IDX_W = 8;
  localparam int WAY_W     = 4;
  localparam int DRAW_W    = 7;
  localparam int MASK_W    = 16;
  localparam int GROUP_W   = 2;
  localparam int IN_DATA_W  = 40;  // 35 payload bits padded to whole bytes
  localparam int OUT_DATA_W = 8;   // 6 payload bits padded to whole bytes

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_PRIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_PCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_MODE  = 2'd2;

  localparam logic [DRAW_W-1:0] NEAR_PCT_RST = 7'd3;

  typedef enum logic [1:0] {
    ACT_HIT        = 2'd0,
    ACT_INSERT     = 2'd1,
    ACT_INVALIDATE = 2'd2,
    ACT_VICTIM     = 2'd3
  } action_e;

  // Victim groups; the numeric order is also the search priority
  typedef enum logic [GROUP_W-1:0] {
    GRP_INVALID = 2'd0,
    GRP_ABSENT  = 2'd1,
    GRP_PRESENT = 2'd2
  } group_e;

  typedef struct packed {
    logic start;
    logic l2_mode;
  } scan_ctl_t;

  typedef struct packed {
    logic   done;
    group_e group;
  } scan_sts_t;

endpackage

@@ hw/rtl/brrip_ram.sv @@
`timescale 1ns / 1ps

module brrip_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/brrip_scan.sv @@
`timescale 1ns / 1ps

module brrip_scan #(
  parameter int RRPV_BITS = 2,
  parameter int WAYS      = 16,
  localparam int IX_W     = $clog2(WAYS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brrip_pkg::scan_ctl_t          ctl_i,
  input  logic [WAYS*RRPV_BITS-1:0]     rrpv_i,
  input  logic [WAYS-1:0]               valid_i,
  input  logic [WAYS-1:0]               upper_i,
  output brrip_pkg::scan_sts_t          sts_o,
  output logic [IX_W-1:0]               victim_way_o
);
  import brrip_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [IX_W-1:0]      idx_q, idx_d;
  logic [IX_W-1:0]      best_way_q;
  group_e               best_cat_q;
  group_e               best_grp_q;
  logic [RRPV_BITS-1:0] best_key_q;

  logic [RRPV_BITS-1:0] cur_val;
  logic [RRPV_BITS-1:0] cur_key;
  logic                 cur_vld;
  logic                 cur_up;
  group_e               cur_cat;
  group_e               cur_grp;
  logic                 take;
  logic                 last;

  always_comb begin
    cur_val = rrpv_i[idx_q*RRPV_BITS +: RRPV_BITS];
    cur_vld = valid_i[idx_q];
    cur_up  = upper_i[idx_q];
    // Ranking class: normal mode only splits invalid from valid
    if (!cur_vld) begin
      cur_cat = GRP_INVALID;
    end else if (ctl_i.l2_mode && cur_up) begin
      cur_cat = GRP_PRESENT;
    end else begin
      cur_cat = GRP_ABSENT;
    end
    if (!cur_vld) begin
      cur_grp = GRP_INVALID;
    end else if (cur_up) begin
      cur_grp = GRP_PRESENT;
    end else begin
      cur_grp = GRP_ABSENT;
    end
    // Normal mode takes the first invalid way regardless of its value
    cur_key = (!cur_vld && !ctl_i.l2_mode) ? '0 : cur_val;
    take = (idx_q == '0) || (cur_cat < best_cat_q) ||
           ((cur_cat == best_cat_q) && (cur_key > best_key_q));
    last = (idx_q == IX_W'(WAYS - 1));

    busy_d = busy_q;
    idx_d  = idx_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      idx_d = idx_q + IX_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !ctl_i.start && take) begin
      best_way_q <= idx_q;
      best_cat_q <= cur_cat;
      best_grp_q <= cur_grp;
      best_key_q <= cur_key;
    end
  end

  assign sts_o.done   = done_q;
  assign sts_o.group  = best_grp_q;
  assign victim_way_o = best_way_q;

endmodule

@@ hw/rtl/bimodal_rrip_victim_select.sv @@
`timescale 1ns / 1ps

// Bimodal RRIP replacement state for a set-associative cache. Each item on the
// slave stream is one action on one set: a hit, an insert, an invalidate or a
// victim request; every item yields exactly one transfer on the master stream
// (the victim way and its group for a victim request, zeros otherwise). The
// per-way re-reference values and valid bits of a set live together in one
// word of a synchronous RAM, so each item is a read, a modify and a write
// back of that word. The block works on one item at a time: a hit, insert or
// invalidate goes through accept, RAM read and write back; a victim request
// adds a victim search between the read and the write back, which walks the
// ways of the set one per cycle. A result waiting in the output register does
// not hold off the next item, only its write back. After reset the block
// sweeps the RAM to zero, one set per cycle, and takes no item until the
// sweep is done; configuration writes are taken at any time but must only
// change while the block is idle.
module bimodal_rrip_victim_select #(
  parameter int RRPV_BITS = brrip_pkg::RRPV_BITS_DEF,
  parameter int WAYS      = brrip_pkg::WAYS_DEF,
  parameter int SETS      = brrip_pkg::SETS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] set_index, [11:8] way, [18:12] draw, [34:19] in_upper_mask, [39:35] zero
  input  logic [brrip_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                       s_axis_tuser,
  // master stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [3:0] victim_way, [5:4] victim_group, [7:6] zero
  output logic [brrip_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [brrip_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [brrip_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import brrip_pkg::*;

  localparam int SA_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int IX_W  = $clog2(WAYS);
  localparam int RV_W  = WAYS * RRPV_BITS;
  localparam int WW    = WAYS * (RRPV_BITS + 1);
  localparam int LUT_N = 1 << SET_IDX_W;
  localparam logic [RRPV_BITS-1:0] MAXV = '1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration registers
  logic              hit_prio_q, hit_prio_d;
  logic [DRAW_W-1:0] near_pct_q, near_pct_d;
  logic              l2_mode_q, l2_mode_d;

  // current item
  action_e           act_q;
  logic [SA_W-1:0]   set_q;
  logic [WAY_W-1:0]  way_q;
  logic [DRAW_W-1:0] draw_q;
  logic [MASK_W-1:0] mask_q;
  logic [WW-1:0]     word_q;

  logic [SA_W-1:0]   clr_q, clr_d;

  logic                 m_valid_q, m_valid_d;
  logic [WAY_W-1:0]     m_way_q;
  group_e               m_grp_q;

  logic [SA_W-1:0]      set_lut [LUT_N];
  logic                 in_fire;
  logic                 out_load;

  logic                 ram_we;
  logic [SA_W-1:0]      ram_waddr;
  logic [WW-1:0]        ram_wdata;
  logic [WW-1:0]        ram_rdata;

  scan_ctl_t            scan_ctl;
  scan_sts_t            scan_sts;
  logic [IX_W-1:0]      vict_way;

  logic [RRPV_BITS-1:0] cur_rrpv [WAYS];
  logic [WAYS-1:0]      cur_valid;
  logic [WAYS-1:0]      upper;
  logic [WW-1:0]        new_word;
  logic [RRPV_BITS-1:0] vict_val;
  logic [RRPV_BITS-1:0] age_d;
  logic                 age_en;
  logic                 way_ok;
  logic [IX_W-1:0]      way_ix;
  logic                 near;
  logic [RRPV_BITS-1:0] nv;
  logic                 nvl;
  logic [RRPV_BITS:0]   sum;

  // Fold the set index into range with a constant table
  for (genvar g = 0; g < LUT_N; g++) begin : g_set_lut
    assign set_lut[g] = SA_W'(g % SETS);
  end

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // Configuration decode
  always_comb begin
    hit_prio_d = hit_prio_q;
    near_pct_d = near_pct_q;
    l2_mode_d  = l2_mode_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HIT_PRIO: hit_prio_d = cfg_data_i[0];
        CFG_NEAR_PCT: near_pct_d = cfg_data_i;
        CFG_L2_MODE:  l2_mode_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer: clear sweep, then read, optional victim scan, write back
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SA_W'(1);
        if (clr_q == SA_W'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = (act_q == ACT_VICTIM) ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (scan_sts.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign scan_ctl.start   = (state_q == ST_READ) && (act_q == ACT_VICTIM);
  assign scan_ctl.l2_mode = l2_mode_q;

  // Unpack the set word
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      cur_rrpv[w] = word_q[w*RRPV_BITS +: RRPV_BITS];
    end
    cur_valid = word_q[RV_W +: WAYS];
  end

  // Ways beyond the mask width count as absent from the upper cache
  assign upper = WAYS'(mask_q);

  // Modify: apply the action to the set word
  always_comb begin
    way_ok   = ({{(32-WAY_W){1'b0}}, way_q} < 32'(WAYS));
    way_ix   = IX_W'(way_q);
    near     = (draw_q <= near_pct_q);
    vict_val = cur_rrpv[vict_way];
    age_d    = MAXV - vict_val;
    // Normal mode ages only when no invalid way was found
    age_en   = l2_mode_q || (scan_sts.group != GRP_INVALID);
    new_word = '0;
    for (int w = 0; w < WAYS; w++) begin
      nv  = cur_rrpv[w];
      nvl = cur_valid[w];
      sum = {1'b0, cur_rrpv[w]} + {1'b0, age_d};
      unique case (act_q)
        ACT_HIT: begin
          if (way_ok && (way_ix == IX_W'(w))) begin
            if (hit_prio_q) begin
              nv = '0;
            end else if (cur_rrpv[w] != '0) begin
              nv = cur_rrpv[w] - RRPV_BITS'(1);
            end
          end
        end
        ACT_INSERT: begin
          if (way_ok && (way_ix == IX_W'(w))) begin
            nv  = near ? (MAXV - RRPV_BITS'(1)) : MAXV;
            nvl = 1'b1;
          end
        end
        ACT_INVALIDATE: begin
          if (way_ok && (way_ix == IX_W'(w))) begin
            nvl = 1'b0;
          end
        end
        ACT_VICTIM: begin
          if (age_en) begin
            nv = (sum > {1'b0, MAXV}) ? MAXV : sum[RRPV_BITS-1:0];
          end
        end
        default: ;
      endcase
      new_word[w*RRPV_BITS +: RRPV_BITS] = nv;
      new_word[RV_W + w]                 = nvl;
    end
  end

  // Write back, or zero the set during the clear sweep
  always_comb begin
    ram_we    = (state_q == ST_CLEAR) || out_load;
    ram_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;
    ram_wdata = (state_q == ST_CLEAR) ? '0 : new_word;
  end

  // Output register: free it on a transfer, load it on write back
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (out_load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      m_valid_q  <= 1'b0;
      hit_prio_q <= 1'b0;
      near_pct_q <= NEAR_PCT_RST;
      l2_mode_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      m_valid_q  <= m_valid_d;
      hit_prio_q <= hit_prio_d;
      near_pct_q <= near_pct_d;
      l2_mode_q  <= l2_mode_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= action_e'(s_axis_tuser);
      set_q  <= set_lut[s_axis_tdata[SET_IDX_W-1:0]];
      way_q  <= s_axis_tdata[SET_IDX_W +: WAY_W];
      draw_q <= s_axis_tdata[SET_IDX_W+WAY_W +: DRAW_W];
      mask_q <= s_axis_tdata[SET_IDX_W+WAY_W+DRAW_W +: MASK_W];
    end
    if (state_q == ST_READ) begin
      word_q <= ram_rdata;
    end
    if (out_load) begin
      if (act_q == ACT_VICTIM) begin
        m_way_q <= WAY_W'(vict_way);
        m_grp_q <= scan_sts.group;
      end else begin
        m_way_q <= '0;
        m_grp_q <= GRP_INVALID;
      end
    end
  end

  brrip_ram #(
    .WIDTH (WW),
    .DEPTH (SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (set_lut[s_axis_tdata[SET_IDX_W-1:0]]),
    .rdata_o (ram_rdata)
  );

  brrip_scan #(
    .RRPV_BITS (RRPV_BITS),
    .WAYS      (WAYS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .rrpv_i       (word_q[RV_W-1:0]),
    .valid_i      (cur_valid),
    .upper_i      (upper),
    .sts_o        (scan_sts),
    .victim_way_o (vict_way)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_grp_q, m_way_q};

endmodule

@@ hw/rtl/brrip_chk.sv @@
`timescale 1ns / 1ps

module brrip_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic [1:0] pend_q, pend_d;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Items taken in but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_fire && !out_fire) begin
      pend_d = pend_q + 2'd1;
    end else if (out_fire && !in_fire) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One item in work: drop ready right after a transfer in
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("item accepted while another is in work");

  // No result without an item behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result without a pending item");

  // At most one item in work plus one result waiting
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items outstanding");

endmodule

bind bimodal_rrip_victim_select brrip_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
